// File: hdl/trbg_pkg.sv
// Shared types and constants for the tiered retry backoff gate.
`default_nettype none

package trbg_pkg;

   localparam int unsigned TickWidth  = 32;
   localparam int unsigned DelayWidth = 16;
   localparam int unsigned CountWidth = 2;
   localparam int unsigned FuncWidth  = 3;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [DelayWidth-1:0] FirstDelayReset    = 16'd2;
   localparam logic [DelayWidth-1:0] SecondDelayReset   = 16'd5;
   localparam logic [DelayWidth-1:0] RecoveryDelayReset = 16'd20;

   localparam logic [CountWidth-1:0] CountMax = 2'd3;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_FAILURE = 3'd0,
      FUNC_PREPARE = 3'd1,
      FUNC_SUCCESS = 3'd2,
      FUNC_RESTORE = 3'd3,
      FUNC_CLEAR   = 3'd4
   } func_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FIRST_DELAY    = 2'd0,
      CSR_SECOND_DELAY   = 2'd1,
      CSR_RECOVERY_DELAY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  proceed;
      logic                  restore_bus;
      logic [CountWidth-1:0] failure_count;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hdl/tiered_retry_backoff_gate.sv
// Top level of the tiered retry backoff gate: event decode, state update and output buffer.
//
// Events arrive on the req_ channel (valid/ready); each accepted word produces
// exactly one response word on the rsp_ channel. The event is decoded against
// the current backoff state in the cycle it is accepted, the state is updated at
// that edge, and the response is registered in the output register, or in the
// skid entry while it is held. Throughput is one event per cycle while req_ready
// is high; the 32-bit deadline add and wrap-safe subtract-compare are combinational.
// The response side has an output register plus one skid entry, so an event can
// still be accepted while a finished response waits. When the receiver stalls
// with both entries full, req_ready drops and rises again in the cycle after
// the receiver takes a word.
// The csr_ port writes the three delay registers at any clock edge with
// csr_write_enable high; index three is ignored. Delays should only change
// while no event is in flight.
// Synchronous reset restores the delays to 2, 5 and 20 ms, clears the
// deadline, the pending recovery flag and the failure count, and empties the
// response buffer.
`default_nettype none

module tiered_retry_backoff_gate
   import trbg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [FuncWidth-1:0]     req_func,
   input  wire logic [TickWidth-1:0]     req_now_ms,
   input  wire logic                     req_transport_related,
   input  wire logic                     req_scheduler_running,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic                     rsp_proceed,
   output      logic                     rsp_restore_bus,
   output      logic [CountWidth-1:0]    rsp_failure_count,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [DelayWidth-1:0]    csr_write_data
);

   logic [DelayWidth-1:0] first_delay_ff, second_delay_ff, recovery_delay_ff;

   logic [TickWidth-1:0]  deadline_ff, deadline_in;
   logic                  pending_ff, pending_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  out_valid_ff, out_valid_in;
   rsp_word_type          out_word_ff, out_word_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_word_type          skid_word_ff, skid_word_in;

   logic                  req_accept;
   logic                  rsp_pop;
   logic [CountWidth-1:0] fail_count;
   logic [DelayWidth-1:0] fail_delay;
   logic [TickWidth-1:0]  fail_deadline;
   logic [TickWidth-1:0]  since_deadline;
   logic                  may_proceed;
   rsp_word_type          new_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff    <= FirstDelayReset;
         second_delay_ff   <= SecondDelayReset;
         recovery_delay_ff <= RecoveryDelayReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_DELAY:    first_delay_ff    <= csr_write_data;
            CSR_SECOND_DELAY:   second_delay_ff   <= csr_write_data;
            CSR_RECOVERY_DELAY: recovery_delay_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = out_valid_ff && rsp_ready;

   always_comb begin
      if (!req_transport_related) begin
         fail_count = '0;
      end else if (count_ff == CountMax) begin
         fail_count = CountMax;
      end else begin
         fail_count = count_ff + 1'b1;
      end
   end

   always_comb begin
      if (req_transport_related && fail_count == CountMax) begin
         fail_delay = recovery_delay_ff;
      end else if (req_transport_related && fail_count == 2'd2) begin
         fail_delay = second_delay_ff;
      end else begin
         fail_delay = first_delay_ff;
      end
   end

   assign fail_deadline  = req_now_ms + {{(TickWidth-DelayWidth){1'b0}}, fail_delay};
   assign since_deadline = req_now_ms - deadline_ff;
   assign may_proceed    = (deadline_ff == '0) || !since_deadline[TickWidth-1];

   always_comb begin
      deadline_in = deadline_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      new_word    = '0;
      unique case (req_func)
         FUNC_FAILURE: begin
            deadline_in = fail_deadline;
            count_in    = fail_count;
            if (req_transport_related && fail_count == CountMax) begin
               pending_in = 1'b1;
            end
         end
         FUNC_PREPARE: begin
            if (may_proceed) begin
               deadline_in      = '0;
               new_word.proceed = 1'b1;
               if (pending_ff) begin
                  new_word.restore_bus = 1'b1;
                  pending_in           = 1'b0;
                  count_in             = '0;
               end
            end
         end
         FUNC_SUCCESS: begin
            count_in = '0;
         end
         FUNC_RESTORE: begin
            if (req_scheduler_running) begin
               pending_in  = 1'b1;
               deadline_in = '0;
            end else begin
               new_word.restore_bus = 1'b1;
               pending_in           = 1'b0;
               count_in             = '0;
            end
         end
         FUNC_CLEAR: begin
            deadline_in = '0;
            pending_in  = 1'b0;
            count_in    = '0;
         end
         default: begin
         end
      endcase
      new_word.failure_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= '0;
         pending_ff  <= 1'b0;
         count_ff    <= '0;
      end else if (req_accept) begin
         deadline_ff <= deadline_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_word_in  = new_word;
         end
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
         skid_word_in  = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_proceed       = out_word_ff.proceed;
   assign rsp_restore_bus   = out_word_ff.restore_bus;
   assign rsp_failure_count = out_word_ff.failure_count;

   skid_needs_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid entry holds a word while the output register is empty.");

   restore_clears_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_restore_bus) |-> (rsp_failure_count == '0))
      else $error("Bus restore reported with a nonzero failure count.");

   clear_empties_state: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_func == FUNC_CLEAR) |=>
         (deadline_ff == '0 && !pending_ff && count_ff == '0))
      else $error("Clear event left backoff state behind.");

   proceed_clears_deadline: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_func == FUNC_PREPARE && may_proceed) |=> (deadline_ff == '0))
      else $error("Proceed left a backoff deadline armed.");

endmodule

`default_nettype wire

// File: tb/trbg_checker.sv
// Response checker for the tiered retry backoff gate: predicts each response word and compares.
`timescale 1ns / 1ps
`default_nettype none

module trbg_checker
   import trbg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [FuncWidth-1:0]     req_func,
   input  wire logic [TickWidth-1:0]     req_now_ms,
   input  wire logic                     req_transport_related,
   input  wire logic                     req_scheduler_running,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic                     rsp_proceed,
   input  wire logic                     rsp_restore_bus,
   input  wire logic [CountWidth-1:0]    rsp_failure_count,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [DelayWidth-1:0]    csr_write_data,
   output      int                       error_count,
   output      int                       pending_count
);

   logic [DelayWidth-1:0] first_delay;
   logic [DelayWidth-1:0] second_delay;
   logic [DelayWidth-1:0] recovery_delay;
   logic [TickWidth-1:0]  deadline;
   logic                  recovery_pending;
   logic [CountWidth-1:0] fail_count;
   rsp_word_type          expected_words[$];
   rsp_word_type          want;
   rsp_word_type          got;
   int                    errors = 0;

   task automatic gate_event(input logic [FuncWidth-1:0] code, input logic [TickWidth-1:0] now,
                             input logic transport, input logic sched,
                             output rsp_word_type word);
      logic [TickWidth-1:0] elapsed;
      word = '0;
      case (code)
         FUNC_FAILURE: begin
            if (transport) begin
               if (fail_count != CountMax) begin
                  fail_count = fail_count + 1'b1;
               end
               if (fail_count == 2'd1) begin
                  deadline = now + {{(TickWidth-DelayWidth){1'b0}}, first_delay};
               end else if (fail_count == 2'd2) begin
                  deadline = now + {{(TickWidth-DelayWidth){1'b0}}, second_delay};
               end else begin
                  recovery_pending = 1'b1;
                  deadline = now + {{(TickWidth-DelayWidth){1'b0}}, recovery_delay};
               end
            end else begin
               deadline   = now + {{(TickWidth-DelayWidth){1'b0}}, first_delay};
               fail_count = '0;
            end
         end
         FUNC_PREPARE: begin
            elapsed = now - deadline;
            if (deadline == '0 || !elapsed[TickWidth-1]) begin
               deadline = '0;
               if (recovery_pending) begin
                  word.restore_bus = 1'b1;
                  recovery_pending = 1'b0;
                  fail_count       = '0;
               end
               word.proceed = 1'b1;
            end
         end
         FUNC_SUCCESS: begin
            fail_count = '0;
         end
         FUNC_RESTORE: begin
            if (sched) begin
               recovery_pending = 1'b1;
               deadline         = '0;
            end else begin
               word.restore_bus = 1'b1;
               recovery_pending = 1'b0;
               fail_count       = '0;
            end
         end
         FUNC_CLEAR: begin
            deadline         = '0;
            recovery_pending = 1'b0;
            fail_count       = '0;
         end
         default: begin
         end
      endcase
      word.failure_count = fail_count;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_delay      = FirstDelayReset;
         second_delay     = SecondDelayReset;
         recovery_delay   = RecoveryDelayReset;
         deadline         = '0;
         recovery_pending = 1'b0;
         fail_count       = '0;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_proceed, rsp_restore_bus, rsp_failure_count};
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t: response word with none expected, actual %b/%b/%0d", $time,
                        got.proceed, got.restore_bus, got.failure_count);
            end else begin
               want = expected_words.pop_front();
               if (got.proceed !== want.proceed) begin
                  errors++;
                  $display("%0t: proceed mismatch, expected %b, actual %b", $time,
                           want.proceed, got.proceed);
               end
               if (got.restore_bus !== want.restore_bus) begin
                  errors++;
                  $display("%0t: restore_bus mismatch, expected %b, actual %b", $time,
                           want.restore_bus, got.restore_bus);
               end
               if (got.failure_count !== want.failure_count) begin
                  errors++;
                  $display("%0t: failure_count mismatch, expected %0d, actual %0d", $time,
                           want.failure_count, got.failure_count);
               end
            end
         end
         if (req_valid && req_ready) begin
            gate_event(req_func, req_now_ms, req_transport_related, req_scheduler_running,
                       want);
            expected_words.push_back(want);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FIRST_DELAY:    first_delay    = csr_write_data;
               CSR_SECOND_DELAY:   second_delay   = csr_write_data;
               CSR_RECOVERY_DELAY: recovery_delay = csr_write_data;
               default: begin
               end
            endcase
         end
      end
      error_count   <= errors;
      pending_count <= expected_words.size();
   end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench top for the tiered retry backoff gate: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import trbg_pkg::*;

   localparam int PhaseCount     = 4;
   localparam int PhaseItems     = 160;
   localparam int LongHold       = 60;
   localparam int SettleCycles   = 8;
   localparam int WatchdogLimit  = 2000;
   localparam logic [FuncWidth-1:0]     FuncUnusedFirst = 3'd5;
   localparam logic [FuncWidth-1:0]     FuncUnusedLast  = 3'd7;
   localparam logic [CsrIndexWidth-1:0] CsrIndexUnused  = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FuncWidth-1:0]     req_func = '0;
   logic [TickWidth-1:0]     req_now_ms = '0;
   logic                     req_transport_related = 1'b0;
   logic                     req_scheduler_running = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_proceed;
   logic                     rsp_restore_bus;
   logic [CountWidth-1:0]    rsp_failure_count;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [DelayWidth-1:0]    csr_write_data = '0;
   int                       error_count;
   int                       pending_count;

   bit                    hold_rsp = 1'b0;
   bit                    no_idle = 1'b0;
   int                    idle_cycles = 0;
   logic [DelayWidth-1:0] first_ms = FirstDelayReset;
   logic [DelayWidth-1:0] second_ms = SecondDelayReset;
   logic [DelayWidth-1:0] recovery_ms = RecoveryDelayReset;

   tiered_retry_backoff_gate DUT (.*);

   trbg_checker checker_inst (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic send_event(input logic [FuncWidth-1:0] code, input logic [TickWidth-1:0] now,
                             input bit transport, input bit sched);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_func              <= code;
      req_now_ms            <= now;
      req_transport_related <= transport;
      req_scheduler_running <= sched;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic configure(input logic [DelayWidth-1:0] first_val,
                            input logic [DelayWidth-1:0] second_val,
                            input logic [DelayWidth-1:0] recovery_val);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FIRST_DELAY;
      csr_write_data   <= first_val;
      @(posedge clock);
      csr_index        <= CSR_SECOND_DELAY;
      csr_write_data   <= second_val;
      @(posedge clock);
      csr_index        <= CSR_RECOVERY_DELAY;
      csr_write_data   <= recovery_val;
      @(posedge clock);
      csr_index        <= CsrIndexUnused;
      csr_write_data   <= DelayWidth'($urandom());
      @(posedge clock);
      csr_write_enable <= 1'b0;
      first_ms    = first_val;
      second_ms   = second_val;
      recovery_ms = recovery_val;
   endtask

   // The receiver alternates ready runs with random stalls, plus one long hold on request.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12)) @(posedge clock);
            if (pick_gap() > 0) begin
               rsp_ready <= 1'b0;
               repeat (pick_gap() + 1) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("tiered_retry_backoff_gate verification failed");
         $finish;
      end
   end

   initial begin
      logic [TickWidth-1:0]  tick;
      logic [TickWidth-1:0]  now;
      logic [TickWidth-1:0]  last_fail_ms;
      logic [DelayWidth-1:0] d0;
      logic [DelayWidth-1:0] d1;
      logic [DelayWidth-1:0] d2;
      int                    roll;
      int                    max_step;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed sequence with the reset delays of 2, 5 and 20 ms.
      send_event(FUNC_PREPARE, 32'd0, 1'b1, 1'b1);
      send_event(FUNC_FAILURE, 32'd100, 1'b1, 1'b0);
      send_event(FUNC_PREPARE, 32'd101, 1'b0, 1'b1);
      send_event(FUNC_PREPARE, 32'd102, 1'b0, 1'b0);
      send_event(FUNC_FAILURE, 32'd110, 1'b1, 1'b1);
      send_event(FUNC_FAILURE, 32'd120, 1'b1, 1'b0);
      send_event(FUNC_FAILURE, 32'd130, 1'b1, 1'b0);
      send_event(FUNC_PREPARE, 32'd149, 1'b0, 1'b0);
      send_event(FUNC_PREPARE, 32'd150, 1'b0, 1'b0);
      // A deadline that wraps to exactly zero reads as no backoff.
      send_event(FUNC_FAILURE, 32'hFFFF_FFFE, 1'b0, 1'b1);
      send_event(FUNC_PREPARE, 32'hFFFF_FFFE, 1'b1, 1'b0);
      send_event(FUNC_FAILURE, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_event(FUNC_PREPARE, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_event(FUNC_PREPARE, 32'd0, 1'b1, 1'b1);
      send_event(FUNC_PREPARE, 32'd1, 1'b0, 1'b0);
      send_event(FUNC_FAILURE, 32'd10, 1'b1, 1'b0);
      send_event(FUNC_SUCCESS, 32'd12, 1'b1, 1'b1);
      send_event(FUNC_RESTORE, 32'd20, 1'b0, 1'b1);
      send_event(FUNC_PREPARE, 32'd20, 1'b1, 1'b0);
      send_event(FUNC_FAILURE, 32'd25, 1'b1, 1'b0);
      send_event(FUNC_RESTORE, 32'd26, 1'b1, 1'b0);
      send_event(FUNC_FAILURE, 32'd30, 1'b1, 1'b1);
      send_event(FUNC_CLEAR, 32'h8000_0000, 1'b1, 1'b1);
      for (int k = FuncUnusedFirst; k <= FuncUnusedLast; k++) begin
         send_event(FuncWidth'(k), $urandom(), 1'($urandom()), 1'($urandom()));
      end

      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: begin
               d0 = DelayWidth'($urandom_range(1, 16));
               d1 = DelayWidth'($urandom_range(1, 40));
               d2 = DelayWidth'($urandom_range(1, 64));
            end
            1: begin
               d0 = '0;
               d1 = '0;
               d2 = '0;
            end
            2: begin
               d0 = '1;
               d1 = '1;
               d2 = '1;
            end
            default: begin
               d0 = DelayWidth'($urandom_range(0, 65535));
               d1 = DelayWidth'($urandom_range(0, 65535));
               d2 = DelayWidth'($urandom_range(0, 65535));
            end
         endcase
         drain_responses();
         configure(d0, d1, d2);
         max_step = 3 + ((d0 > d1 ? (d0 > d2 ? d0 : d2) : (d1 > d2 ? d1 : d2)) / 3);
         tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom();
         last_fail_ms = tick;

         for (int i = 0; i < PhaseItems; i++) begin
            no_idle = (i % 80) < 20;
            if (phase == 0 && i == 30) begin
               hold_rsp = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               send_event(FuncWidth'($urandom_range(FUNC_FAILURE, FuncUnusedLast)), $urandom(),
                          1'($urandom()), 1'($urandom()));
            end else begin
               tick = tick + $urandom_range(0, max_step);
               now = tick;
               roll = $urandom_range(0, 99);
               if (roll < 36) begin
                  last_fail_ms = now;
                  send_event(FUNC_FAILURE, now, $urandom_range(0, 9) < 7, 1'($urandom()));
               end else if (roll < 72) begin
                  if ($urandom_range(0, 3) == 0) begin
                     case ($urandom_range(0, 2))
                        0: now = last_fail_ms + {{(TickWidth-DelayWidth){1'b0}}, first_ms};
                        1: now = last_fail_ms + {{(TickWidth-DelayWidth){1'b0}}, second_ms};
                        default: now = last_fail_ms
                                       + {{(TickWidth-DelayWidth){1'b0}}, recovery_ms};
                     endcase
                     now = now - $urandom_range(0, 1);
                  end
                  send_event(FUNC_PREPARE, now, 1'($urandom()), 1'($urandom()));
               end else if (roll < 82) begin
                  send_event(FUNC_SUCCESS, now, 1'($urandom()), 1'($urandom()));
               end else if (roll < 91) begin
                  send_event(FUNC_RESTORE, now, 1'($urandom()), 1'($urandom()));
               end else if (roll < 95) begin
                  send_event(FUNC_CLEAR, now, 1'($urandom()), 1'($urandom()));
               end else begin
                  send_event(FuncWidth'($urandom_range(FuncUnusedFirst, FuncUnusedLast)), now,
                             1'($urandom()), 1'($urandom()));
               end
            end
         end
      end

      drain_responses();
      if (error_count == 0 && pending_count == 0) begin
         $display("tiered_retry_backoff_gate verification clean");
      end else begin
         $display("tiered_retry_backoff_gate verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: tiered_retry_backoff_gate.f
hdl/trbg_pkg.sv
hdl/tiered_retry_backoff_gate.sv
tb/trbg_checker.sv
tb/tb.sv
